[design/tsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the timeout slot pool.
package tsp_pkg;

    localparam int SLOTS_DEF = 4;
    localparam int CNT_W     = 32;
    localparam int SEL_W     = 2;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET     = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd             command;
        logic [CNT_W-1:0] timeout;
        logic [SEL_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [SEL_W-1:0] slot_used;
        logic             granted;
        logic [CNT_W-1:0] remaining;
        logic [CNT_W-1:0] tick_count;
    } t_rsp;

endpackage

[design/tsp_in_reg.sv]
`timescale 1ns / 1ps
// Input register stage that holds one command transaction.
module tsp_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tsp_pkg::t_req i_req,
    output logic          o_valid,
    output tsp_pkg::t_req o_req,
    input  logic          i_advance
);
    import tsp_pkg::*;

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

[design/tsp_slot_bank.sv]
`timescale 1ns / 1ps
// Countdown slots, free-slot priority encoder and wrapping tick counter.
module tsp_slot_bank #(
    parameter int SLOTS = tsp_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  tsp_pkg::t_req i_req,
    output tsp_pkg::t_rsp o_rsp
);
    import tsp_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W = (IDX_W > SEL_W) ? IDX_W : SEL_W;

    logic [CNT_W-1:0] r_cnt [SLOTS];
    logic [CNT_W-1:0] r_ticks;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [EXT_W-1:0] used_ext;
    logic [EXT_W-1:0] sel_ext;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_in_range;

    // lowest slot holding zero
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_cnt[i] == '0) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign used_ext    = EXT_W'(free_idx);
    assign sel_ext     = EXT_W'(i_req.slot);
    assign rd_idx      = sel_ext[IDX_W-1:0];
    assign rd_in_range = (32'(i_req.slot) < 32'(SLOTS));

    always_comb begin
        o_rsp            = '0;
        o_rsp.tick_count = r_ticks;
        unique case (i_req.command)
            CMD_TICK: begin
                o_rsp.tick_count = r_ticks + CNT_W'(1);
            end
            CMD_SET: begin
                o_rsp.granted = free_found;
                if (free_found) begin
                    o_rsp.slot_used = used_ext[SEL_W-1:0];
                end
            end
            CMD_READ: begin
                if (rd_in_range) begin
                    o_rsp.remaining = r_cnt[rd_idx];
                end
            end
            CMD_RESTART: begin
                o_rsp.tick_count = '0;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_fire) begin
            unique case (i_req.command)
                CMD_TICK: begin
                    r_ticks <= r_ticks + CNT_W'(1);
                    for (int i = 0; i < SLOTS; i++) begin
                        if (r_cnt[i] != '0) begin
                            r_cnt[i] <= r_cnt[i] - CNT_W'(1);
                        end
                    end
                end
                CMD_SET: begin
                    if (free_found) begin
                        r_cnt[free_idx] <= i_req.timeout;
                    end
                end
                CMD_READ: begin
                    r_ticks <= r_ticks;
                end
                CMD_RESTART: begin
                    r_ticks <= '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        r_cnt[i] <= '0;
                    end
                end
                default: begin
                    r_ticks <= r_ticks;
                end
            endcase
        end
    end

endmodule

[design/timeout_slot_pool_core.sv]
`timescale 1ns / 1ps
// A transaction passes through the input register and then the result register before its result is valid.
// Throughput: one transaction per cycle while results are taken; the slot bank finishes each command in one pass.
// The result register lets a new transaction enter while a result waits to be taken.
// Reset (synchronous, active low) clears all slots, the tick counter and both valid flags.
// Top level of the timeout slot pool.
module timeout_slot_pool_core #(
    parameter int SLOTS = tsp_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_timeout,
    input  logic [1:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_slot_used,
    output logic        o_granted,
    output logic [31:0] o_remaining,
    output logic [31:0] o_tick_count
);
    import tsp_pkg::*;

    t_req in_req;
    t_req ex_req;
    t_rsp ex_rsp;
    logic ex_valid;
    logic advance;

    logic r_out_valid;
    t_rsp r_rsp;

    assign in_req.command = t_cmd'(i_command);
    assign in_req.timeout = i_timeout;
    assign in_req.slot    = i_slot;

    assign advance = ex_valid && (!r_out_valid || i_out_ready);

    tsp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_req     (in_req),
        .o_valid   (ex_valid),
        .o_req     (ex_req),
        .i_advance (advance)
    );

    tsp_slot_bank #(
        .SLOTS (SLOTS)
    ) u_slot_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (ex_req),
        .o_rsp   (ex_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp <= ex_rsp;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_used  = r_rsp.slot_used;
    assign o_granted    = r_rsp.granted;
    assign o_remaining  = r_rsp.remaining;
    assign o_tick_count = r_rsp.tick_count;

endmodule

[design/tsp_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the timeout slot pool and its bind to the top level.
module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_slot_used,
    input logic        o_granted,
    input logic [31:0] o_remaining,
    input logic [31:0] o_tick_count
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slot_used)
            && $stable(o_granted) && $stable(o_remaining) && $stable(o_tick_count))
        else $error("result changed while stalled");

    a_ungranted_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_granted |-> o_slot_used == 2'd0)
        else $error("slot_used nonzero without grant");

    a_granted_no_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> o_remaining == 32'd0)
        else $error("granted set reported a remaining count");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a stalled result");

endmodule

bind timeout_slot_pool_core tsp_checker u_tsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_slot_used  (o_slot_used),
    .o_granted    (o_granted),
    .o_remaining  (o_remaining),
    .o_tick_count (o_tick_count)
);
